FILE: hw/rtl/amb_pkg.sv
// ============================================================================
// amb_pkg
// Shared types and constants for the alignment-op to match-block converter.
// ============================================================================
package amb_pkg;

    // Field widths
    localparam int unsigned NAME_W      = 63;
    localparam int unsigned COORD_BITS  = 40;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned TRIM_W      = 16;
    localparam int unsigned OP_W        = 2;

    // Configuration port
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam logic        REG_TRIM    = 1'b0;   // register index bit paddr[2]

    // Operation codes
    localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
    localparam logic [OP_W-1:0] OP_MATCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_GAP_Y  = 2'd2;  // moves x only
    localparam logic [OP_W-1:0] OP_GAP_X  = 2'd3;  // moves y only

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [NAME_W-1:0]     x_name;
        logic [NAME_W-1:0]     y_name;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic                  x_plus;
        logic                  y_plus;
        logic [LEN_W-1:0]      op_length;
    } item_t;

    typedef struct packed {
        logic [NAME_W-1:0]     block_x_name;
        logic [NAME_W-1:0]     block_y_name;
        logic [COORD_BITS-1:0] block_x_start;
        logic [COORD_BITS-1:0] block_y_start;
        logic [LEN_W-1:0]      block_length;
        logic                  same_strand;
    } block_t;

    // Untrimmed block passed from front to back
    typedef struct packed {
        logic [NAME_W-1:0]     x_name;
        logic [NAME_W-1:0]     y_name;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [LEN_W-1:0]      length;
        logic                  same_strand;
    } raw_block_t;

endpackage

FILE: hw/rtl/alignment_ops_to_match_blocks_core.sv
// ============================================================================
// alignment_ops_to_match_blocks_core
// Alignment-op stream to trimmed match-block converter, top level.
// ============================================================================
// Takes one op word per clock while full is low. A header loads names,
// starts and strands; a gap moves one axis; a nonzero match moves both axes
// and yields a block, which is trimmed by the trim register at both ends and
// dropped if nothing is left. The front end keeps the coordinates with one
// adder per axis and does all of its work in the accept cycle, so a new op is
// taken every clock unless full is high. A match is registered in the queue
// between front and back, then moves into the result queue once that has
// room; the result queue's head is read out without a register stage. Full
// rises only when the front-to-back queue (QUEUE_DEPTH words) has filled,
// which happens only after the two-word result queue has filled because
// results are not being popped.
module alignment_ops_to_match_blocks_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // op input
    input  logic                              push,
    input  amb_pkg::item_t                    op_item,
    output logic                              full,
    // block output
    output logic                              empty,
    input  logic                              pop,
    output amb_pkg::block_t                   match_block,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [amb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [amb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [amb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int unsigned RAW_W = $bits(amb_pkg::raw_block_t);
    localparam int unsigned BLK_W = $bits(amb_pkg::block_t);

    logic [amb_pkg::TRIM_W-1:0] trim_reg, trim_next;
    logic                       cfg_wr;
    logic                       accept;
    logic                       raw_push;
    logic                       raw_full;
    logic                       raw_empty;
    logic                       raw_pop;
    amb_pkg::raw_block_t        raw_wr;
    amb_pkg::raw_block_t        raw_rd;
    logic                       out_push;
    logic                       out_full;
    amb_pkg::block_t            out_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == amb_pkg::REG_TRIM);
    assign trim_next = cfg_wr ? pwdata[amb_pkg::TRIM_W-1:0] : trim_reg;
    assign prdata = (paddr[2] == amb_pkg::REG_TRIM)
                  ? {{(amb_pkg::APB_DATA_W - amb_pkg::TRIM_W){1'b0}}, trim_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= '0;
        end
        else
        begin
            trim_reg <= trim_next;
        end
    end

    // Accept an op whenever the front-to-back queue has room
    assign full   = raw_full;
    assign accept = push && !raw_full;

    amb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op_item   (op_item),
        .raw_push  (raw_push),
        .raw_block (raw_wr)
    );

    amb_fifo #(
        .WIDTH (RAW_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_raw_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (raw_push),
        .wr_data (raw_wr),
        .full    (raw_full),
        .rd_en   (raw_pop),
        .rd_data (raw_rd),
        .empty   (raw_empty)
    );

    amb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .trim      (trim_reg),
        .raw_empty (raw_empty),
        .raw_block (raw_rd),
        .raw_pop   (raw_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_block (out_wr)
    );

    amb_fifo #(
        .WIDTH (BLK_W),
        .DEPTH (2)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_wr),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (match_block),
        .empty   (empty)
    );

endmodule

FILE: hw/rtl/amb_fifo.sv
// ============================================================================
// amb_fifo
// Small register-based FIFO with full/empty flags and combinational read.
// ============================================================================
module amb_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store words; storage needs no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fifo occupancy beyond depth");

    a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && !empty) |=> (rd_ptr_reg != $past(rd_ptr_reg)) || (DEPTH == 1))
        else $error("read pointer did not advance on pop");
`endif

endmodule

FILE: hw/rtl/amb_front.sv
// ============================================================================
// amb_front
// Decodes alignment ops, tracks both coordinates, and emits untrimmed blocks.
// ============================================================================
module amb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  amb_pkg::item_t      op_item,
    output logic                raw_push,
    output amb_pkg::raw_block_t raw_block
);

    localparam int unsigned CW = amb_pkg::COORD_BITS;

    logic [CW-1:0]              x_pos_reg, x_pos_next;
    logic [CW-1:0]              y_pos_reg, y_pos_next;
    logic                       x_fwd_reg, x_fwd_next;
    logic                       y_fwd_reg, y_fwd_next;
    logic [amb_pkg::NAME_W-1:0] x_name_reg, x_name_next;
    logic [amb_pkg::NAME_W-1:0] y_name_reg, y_name_next;
    logic [CW-1:0]              len_ext;
    logic [CW-1:0]              x_moved;
    logic [CW-1:0]              y_moved;

    // One adder per axis: forward adds, reverse subtracts
    assign len_ext = CW'(op_item.op_length);
    assign x_moved = x_fwd_reg ? (x_pos_reg + len_ext) : (x_pos_reg - len_ext);
    assign y_moved = y_fwd_reg ? (y_pos_reg + len_ext) : (y_pos_reg - len_ext);

    // Classify the op and update position state
    always_comb
    begin
        x_pos_next  = x_pos_reg;
        y_pos_next  = y_pos_reg;
        x_fwd_next  = x_fwd_reg;
        y_fwd_next  = y_fwd_reg;
        x_name_next = x_name_reg;
        y_name_next = y_name_reg;
        raw_push    = 1'b0;
        if (accept)
        begin
            unique case (op_item.op)
                amb_pkg::OP_HEADER:
                begin
                    x_name_next = op_item.x_name;
                    y_name_next = op_item.y_name;
                    x_pos_next  = op_item.x_start;
                    y_pos_next  = op_item.y_start;
                    x_fwd_next  = op_item.x_plus;
                    y_fwd_next  = op_item.y_plus;
                end
                amb_pkg::OP_GAP_Y:
                begin
                    x_pos_next = x_moved;
                end
                amb_pkg::OP_GAP_X:
                begin
                    y_pos_next = y_moved;
                end
                amb_pkg::OP_MATCH:
                begin
                    if (op_item.op_length != '0)
                    begin
                        x_pos_next = x_moved;
                        y_pos_next = y_moved;
                        raw_push   = 1'b1;
                    end
                end
                default:
                begin
                    x_pos_next = x_pos_reg;
                end
            endcase
        end
    end

    // Block start: current position on plus strand, moved position on minus
    always_comb
    begin
        raw_block.x_name      = x_name_reg;
        raw_block.y_name      = y_name_reg;
        raw_block.x_start     = x_fwd_reg ? x_pos_reg : x_moved;
        raw_block.y_start     = y_fwd_reg ? y_pos_reg : y_moved;
        raw_block.length      = op_item.op_length;
        raw_block.same_strand = (x_fwd_reg == y_fwd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pos_reg  <= '0;
            y_pos_reg  <= '0;
            x_fwd_reg  <= 1'b1;
            y_fwd_reg  <= 1'b1;
            x_name_reg <= '0;
            y_name_reg <= '0;
        end
        else
        begin
            x_pos_reg  <= x_pos_next;
            y_pos_reg  <= y_pos_next;
            x_fwd_reg  <= x_fwd_next;
            y_fwd_reg  <= y_fwd_next;
            x_name_reg <= x_name_next;
            y_name_reg <= y_name_next;
        end
    end

`ifndef SYNTHESIS
    a_header_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_item.op == amb_pkg::OP_HEADER)
        |=> (x_pos_reg == $past(op_item.x_start)) && (y_pos_reg == $past(op_item.y_start)))
        else $error("header did not load start coordinates");

    a_gap_holds_names: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_item.op != amb_pkg::OP_HEADER)
        |=> $stable(x_name_reg) && $stable(y_name_reg))
        else $error("names changed on a non-header op");
`endif

endmodule

FILE: hw/rtl/amb_back.sv
// ============================================================================
// amb_back
// Trims queued blocks, drops those with no length left, and fills the
// result queue.
// ============================================================================
module amb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [amb_pkg::TRIM_W-1:0]    trim,
    input  logic                          raw_empty,
    input  amb_pkg::raw_block_t           raw_block,
    output logic                          raw_pop,
    input  logic                          out_full,
    output logic                          out_push,
    output amb_pkg::block_t               out_block
);

    localparam int unsigned CW = amb_pkg::COORD_BITS;
    localparam int unsigned LW = amb_pkg::LEN_W;

    logic [amb_pkg::TRIM_W:0] cut;
    logic [LW-1:0]            cut_ext;
    logic                     keep;

    // Both ends lose trim bases
    assign cut     = {trim, 1'b0};
    assign cut_ext = LW'(cut);
    assign keep    = (raw_block.length > cut_ext);

    // Drain the queue whenever the result queue has room
    assign raw_pop  = !raw_empty && !out_full;
    assign out_push = raw_pop && keep;

    always_comb
    begin
        out_block.block_x_name  = raw_block.x_name;
        out_block.block_y_name  = raw_block.y_name;
        out_block.block_x_start = raw_block.x_start + CW'(trim);
        out_block.block_y_start = raw_block.y_start + CW'(trim);
        out_block.block_length  = raw_block.length - cut_ext;
        out_block.same_strand   = raw_block.same_strand;
    end

`ifndef SYNTHESIS
    a_len_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> out_block.block_length != '0)
        else $error("emitted block has zero length");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_full |-> !out_push && !raw_pop)
        else $error("back end advanced into a full result queue");
`endif

endmodule

FILE: bench/amb_checker.sv
// ----------------------------------------------------------------------------
// amb_checker
// Watches the op, block and configuration channels of the match-block core,
// tracks alignment state and the trim setting on its own, and compares every
// popped block field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module amb_checker
    import amb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  item_t                 op_item,
    input  logic                  full,
    input  logic                  empty,
    input  logic                  pop,
    input  block_t                match_block,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    blocks_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_ADDR_W-1:0] TRIM_ADDR = {REG_TRIM, 2'b00};

    // Alignment state and configuration as the core should hold them
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic                  x_fwd;
    logic                  y_fwd;
    logic [NAME_W-1:0]     x_seq;
    logic [NAME_W-1:0]     y_seq;
    logic [TRIM_W-1:0]     trim_bases;

    block_t blocks_due[$];

    initial mismatches = 0;
    initial blocks_pending = 0;

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", fname, want, got);
            mismatches++;
        end
    endtask

    // Advance the coordinates for one op word and queue the block it yields
    task automatic advance_alignment(item_t w);
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
        logic [LEN_W:0]        cut;
        block_t                blk;
        case (w.op)
            OP_HEADER:
            begin
                x_seq = w.x_name;
                y_seq = w.y_name;
                x_pos = w.x_start;
                y_pos = w.y_start;
                x_fwd = w.x_plus;
                y_fwd = w.y_plus;
            end
            OP_GAP_Y:
                x_pos = x_fwd ? x_pos + w.op_length : x_pos - w.op_length;
            OP_GAP_X:
                y_pos = y_fwd ? y_pos + w.op_length : y_pos - w.op_length;
            default:
            begin
                if (w.op_length != 0) begin
                    // minus strand: retreat first, block starts at new position
                    if (!x_fwd) x_pos = x_pos - w.op_length;
                    if (!y_fwd) y_pos = y_pos - w.op_length;
                    bx = x_pos;
                    by = y_pos;
                    if (x_fwd) x_pos = x_pos + w.op_length;
                    if (y_fwd) y_pos = y_pos + w.op_length;
                    cut = {trim_bases, 1'b0};
                    if ({1'b0, w.op_length} > cut) begin
                        blk.block_x_name  = x_seq;
                        blk.block_y_name  = y_seq;
                        blk.block_x_start = bx + trim_bases;
                        blk.block_y_start = by + trim_bases;
                        blk.block_length  = w.op_length - cut[LEN_W-1:0];
                        blk.same_strand   = (x_fwd == y_fwd);
                        blocks_due.push_back(blk);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        block_t want;
        if (!rst_n) begin
            x_pos      = '0;
            y_pos      = '0;
            x_fwd      = 1'b1;
            y_fwd      = 1'b1;
            x_seq      = '0;
            y_seq      = '0;
            trim_bases = '0;
            blocks_due.delete();
        end else begin
            // Compare popped block with the oldest prediction
            if (pop && !empty) begin
                if (blocks_due.size() == 0) begin
                    $error("match_block: unexpected word %h", match_block);
                    mismatches++;
                end else begin
                    want = blocks_due.pop_front();
                    check_field("block_x_name", want.block_x_name,
                                match_block.block_x_name);
                    check_field("block_y_name", want.block_y_name,
                                match_block.block_y_name);
                    check_field("block_x_start", want.block_x_start,
                                match_block.block_x_start);
                    check_field("block_y_start", want.block_y_start,
                                match_block.block_y_start);
                    check_field("block_length", want.block_length,
                                match_block.block_length);
                    check_field("same_strand", want.same_strand,
                                match_block.same_strand);
                end
            end
            // Predict from accepted op word
            if (push && !full)
                advance_alignment(op_item);
            // Track trim writes, check reads
            if (psel && penable && pready && paddr == TRIM_ADDR) begin
                if (pwrite)
                    trim_bases = pwdata[TRIM_W-1:0];
                else
                    check_field("prdata", {{(64-TRIM_W){1'b0}}, trim_bases}, prdata);
            end
        end
        blocks_pending = blocks_due.size();
    end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the alignment-op to match-block core.
// Runs a directed pass over strand, wrap and trim corners, then phases of
// random alignments under varied trim settings and flow-control pressure;
// the checker beside the core predicts and compares every block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import amb_pkg::*;

    localparam logic [APB_ADDR_W-1:0] TRIM_ADDR = {REG_TRIM, 2'b00};
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned ITEMS_PER_PHASE = 200;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    item_t                 op_item = '0;
    logic                  full;
    logic                  empty;
    logic                  pop = 1'b0;
    block_t                match_block;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          mismatches;
    int          blocks_pending;
    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_granted = 0;
    int unsigned hold_left = 0;
    logic [TRIM_W-1:0] trim_now = '0;

    alignment_ops_to_match_blocks_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .op_item     (op_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .match_block (match_block),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    amb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .op_item        (op_item),
        .full           (full),
        .empty          (empty),
        .pop            (pop),
        .match_block    (match_block),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .blocks_pending (blocks_pending)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, plus long hold-offs on request
    always @(negedge clk) begin
        if (holds_granted != holds_asked) begin
            holds_granted++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [NAME_W-1:0] pick_name();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        logic [COORD_BITS-1:0] c;
        case ($urandom_range(0, 4))
            0:       c = '0;
            1:       c = '1;
            2:       c = $urandom_range(0, 1000);
            3:       c = '1 - $urandom_range(0, 1000);
            default: c = {$urandom, $urandom};
        endcase
        return c;
    endfunction

    // Lengths cluster around the trim cutoff so both kept and dropped blocks occur
    function automatic logic [LEN_W-1:0] pick_length();
        logic [LEN_W-1:0] cut;
        cut = {trim_now, 1'b0};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            4, 5:    return cut + $urandom_range(0, 4) - 2;
            default: return $urandom_range(1, cut + 40);
        endcase
    endfunction

    // Header word; the ignored length carries random bits
    function automatic item_t header_word(logic [NAME_W-1:0] xn, logic [NAME_W-1:0] yn,
                                          logic [COORD_BITS-1:0] xs,
                                          logic [COORD_BITS-1:0] ys,
                                          logic xp, logic yp);
        item_t w;
        w.op        = OP_HEADER;
        w.x_name    = xn;
        w.y_name    = yn;
        w.x_start   = xs;
        w.y_start   = ys;
        w.x_plus    = xp;
        w.y_plus    = yp;
        w.op_length = $urandom;
        return w;
    endfunction

    // Op word; the ignored header fields carry random bits
    function automatic item_t op_word(logic [OP_W-1:0] code, logic [LEN_W-1:0] len);
        item_t w;
        w = header_word(pick_name(), pick_name(), pick_coord(), pick_coord(),
                        $urandom_range(0, 1), $urandom_range(0, 1));
        w.op        = code;
        w.op_length = len;
        return w;
    endfunction

    function automatic item_t random_header();
        return header_word(pick_name(), pick_name(), pick_coord(), pick_coord(),
                           $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    function automatic item_t random_op();
        logic [OP_W-1:0] code;
        if ($urandom_range(0, 9) < 6)
            code = OP_MATCH;
        else if ($urandom_range(0, 1) == 0)
            code = OP_GAP_Y;
        else
            code = OP_GAP_X;
        return op_word(code, pick_length());
    endfunction

    // Offer one word after optional idle cycles; return at the next falling edge
    task automatic push_word(item_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        op_item <= w;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    // Hold input until every block is out and the pipe has settled
    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (blocks_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(logic wr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TRIM_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write trim (upper bits random, ignored by the register), then read it back
    task automatic set_trim(logic [TRIM_W-1:0] value);
        wait_drained();
        apb_access(1'b1, {16'($urandom), value});
        trim_now = value;
        apb_access(1'b0, '0);
    endtask

    task automatic send_alignments(int unsigned count);
        int unsigned sent;
        int unsigned ops;
        sent = 0;
        while (sent < count) begin
            // now and then keep going from the previous alignment
            if ($urandom_range(0, 9) != 0) begin
                push_word(random_header());
                sent++;
            end
            ops = $urandom_range(1, 12);
            repeat (ops) begin
                push_word(random_op());
                sent++;
            end
        end
    endtask

    task automatic run_directed();
        localparam logic [COORD_BITS-1:0] CMAX = '1;
        // ops before any header use the reset state
        push_word(op_word(OP_MATCH, 5));
        push_word(op_word(OP_GAP_Y, 3));
        push_word(op_word(OP_GAP_X, 4));
        push_word(op_word(OP_MATCH, 2));
        // zero-length match: no block, no movement
        push_word(op_word(OP_MATCH, 0));
        // maximal names and x start, maximal match wraps the x axis forward
        push_word(header_word('1, '1, CMAX, '0, 1'b1, 1'b1));
        push_word(op_word(OP_MATCH, '1));
        push_word(op_word(OP_MATCH, 1));
        // minus/minus from zero wraps backward
        push_word(header_word('0, '0, '0, '0, 1'b0, 1'b0));
        push_word(op_word(OP_MATCH, 10));
        push_word(op_word(OP_GAP_Y, 1));
        push_word(op_word(OP_GAP_X, 2));
        push_word(op_word(OP_MATCH, 1));
        // mixed strands
        push_word(header_word(63'h1234, 63'h5678, 40'h10_0000, 40'h20_0000, 1'b1, 1'b0));
        push_word(op_word(OP_MATCH, 100));
        push_word(op_word(OP_GAP_X, '1));
        push_word(op_word(OP_MATCH, 7));
        push_word(header_word(63'h9, 63'hA, 40'h5, 40'h6, 1'b0, 1'b1));
        push_word(op_word(OP_MATCH, 7));
        // trim cutoff: exactly twice trim is dropped, one more survives
        set_trim(3);
        push_word(op_word(OP_MATCH, 6));
        push_word(op_word(OP_MATCH, 7));
        push_word(op_word(OP_MATCH, 5));
        // largest trim, start near the top so start plus trim wraps
        set_trim('1);
        push_word(header_word('1, '0, CMAX - 1, CMAX, 1'b1, 1'b1));
        push_word(op_word(OP_MATCH, 131070));
        push_word(op_word(OP_MATCH, 131071));
        push_word(op_word(OP_MATCH, '1));
    endtask

    // Main sequence
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        apb_access(1'b0, '0);
        run_directed();

        // no idling, zero trim, one long result hold-off that fills the core
        set_trim('0);
        send_idle_pct = 0;
        pop_stall_pct = 0;
        holds_asked++;
        send_alignments(ITEMS_PER_PHASE);

        // sender mostly idle
        set_trim($urandom_range(1, 16));
        send_idle_pct = 82;
        pop_stall_pct = 0;
        send_alignments(ITEMS_PER_PHASE);

        // receiver mostly stalled, largest trim
        set_trim('1);
        send_idle_pct = 0;
        pop_stall_pct = 82;
        send_alignments(ITEMS_PER_PHASE);

        // both sides idle a quarter of the time
        set_trim($urandom_range(0, 300));
        send_idle_pct = 25;
        pop_stall_pct = 25;
        send_alignments(ITEMS_PER_PHASE);

        // no idling, any trim
        set_trim($urandom_range(0, 65535));
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_alignments(ITEMS_PER_PHASE);

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && blocks_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/amb_pkg.sv
hw/rtl/amb_fifo.sv
hw/rtl/amb_front.sv
hw/rtl/amb_back.sv
hw/rtl/alignment_ops_to_match_blocks_core.sv
bench/amb_checker.sv
bench/testbench.sv
